// ===== sv/lcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lcsd_pkg: shared definitions for the calibration status deframer
// Holds the store geometry, the marker text, the record byte layout and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsd_pkg;

    localparam int LASER_COUNT     = 64;
    localparam int SLOT_BYTES      = 64;
    localparam int STORE_DEPTH     = 4096;
    localparam int MARKER_LEN      = 5;
    localparam int MARKER_DISTANCE = 65 * 64;
    // Offset of the last marker byte from the previous marker start on a hit.
    localparam int HIT_OFFSET      = MARKER_DISTANCE + MARKER_LEN - 1;

    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int SLOT_SHIFT = $clog2(SLOT_BYTES);
    localparam int LASER_W    = (LASER_COUNT > 1) ? $clog2(LASER_COUNT) : 1;
    localparam int OFF_W      = 32;
    localparam int PROG_W     = 3;

    // Each record gathers three runs of seven bytes from its slot.
    localparam int RUN_BYTES  = 7;
    localparam int REC_BYTES  = 3 * RUN_BYTES;
    localparam int STEP_W     = $clog2(REC_BYTES);
    localparam int RUN_A_BASE = 16;
    localparam int RUN_B_BASE = 32;
    localparam int RUN_C_BASE = 48;

    typedef struct packed {
        logic [7:0]  ring_id;
        logic [15:0] vertical_angle;
        logic [15:0] rotation_angle;
        logic [15:0] distance_offset;
        logic [15:0] distance_offset_x;
        logic [15:0] distance_offset_y;
        logic [15:0] vertical_offset;
        logic [15:0] horizontal_offset;
        logic [15:0] focal_range;
        logic [15:0] focal_gradient;
        logic [15:0] intensity_limits;
        logic        last_record;
    } t_record;

    typedef struct packed {
        logic take_byte;  // a status byte transaction completes this cycle
        logic read_step;  // issue the next store read of the current record
        logic load;       // move the assembled record into the output register
    } t_cmd;

    typedef struct packed {
        logic table_hit;  // the incoming byte closes a marker at the right distance
        logic step_last;  // the read being issued is the record's last
        logic laser_last; // the record being assembled is the table's last
        logic out_free;   // the output register can take a record this cycle
    } t_status;

    function automatic logic [7:0] marker_byte(input logic [PROG_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'd85;  // U
            3'd1:    b = 8'd78;  // N
            3'd2:    b = 8'd73;  // I
            3'd3:    b = 8'd84;  // T
            3'd4:    b = 8'd35;  // #
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // Byte offset within a slot of the k-th gathered record byte.
    function automatic logic [SLOT_SHIFT-1:0] slot_offset(input logic [STEP_W-1:0] k);
        logic [SLOT_SHIFT-1:0] off;
        if (k < STEP_W'(RUN_BYTES)) begin
            off = SLOT_SHIFT'(RUN_A_BASE) + SLOT_SHIFT'(k);
        end else if (k < STEP_W'(2 * RUN_BYTES)) begin
            off = SLOT_SHIFT'(RUN_B_BASE) + SLOT_SHIFT'(k - STEP_W'(RUN_BYTES));
        end else begin
            off = SLOT_SHIFT'(RUN_C_BASE) + SLOT_SHIFT'(k - STEP_W'(2 * RUN_BYTES));
        end
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lcsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcsd_ctrl: sequencing of the calibration status deframer
// Runs the byte search, the per-record store reads and the record hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsd_ctrl
    import lcsd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_status i_sts,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_RUN   = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_RUN: begin
                o_ready        = 1'b1;
                o_cmd.take_byte = i_valid;
                if (i_valid && i_sts.table_hit) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_step = 1'b1;
                if (i_sts.step_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.laser_last ? S_DONE : S_READ;
                end
            end
            S_DONE: begin
                // Table delivered: bytes are still taken but have no effect.
                o_ready = 1'b1;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lcsd_datapath.sv =====
// ----------------------------------------------------------------------------
// lcsd_datapath: marker search, byte store and record assembly
// Tracks the marker match and the offset from the last marker, keeps the
// byte store, and gathers each record into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsd_datapath
    import lcsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_status_byte,
    input  wire logic       i_ready,
    input  wire t_cmd       i_cmd,
    output t_status         o_sts,
    output logic            o_valid,
    output t_record         o_record
);

    logic [PROG_W-1:0] r_prog;
    logic              r_have_prev;
    logic [OFF_W-1:0]  r_off;
    logic [STEP_W-1:0] r_step;
    logic [LASER_W-1:0] r_laser;
    logic              r_rd_vld;
    logic [STEP_W-1:0] r_rd_slot;
    logic [7:0]        r_rdata;
    logic [7:0]        r_rec [REC_BYTES];
    logic              r_out_valid;
    t_record           r_out;

    logic [7:0]        mem [STORE_DEPTH];

    logic              byte_match;
    logic              marker_end;
    logic [PROG_W-1:0] n_prog;
    logic              store_we;
    logic [ADDR_W-1:0] rd_addr;
    t_record           n_out;

    // Marker search over the incoming byte.
    always_comb begin
        byte_match = (r_prog < PROG_W'(MARKER_LEN)) && (i_status_byte == marker_byte(r_prog));
        marker_end = byte_match && (r_prog == PROG_W'(MARKER_LEN - 1));
        if (byte_match) begin
            n_prog = marker_end ? '0 : r_prog + 1'b1;
        end else begin
            n_prog = (i_status_byte == marker_byte('0)) ? PROG_W'(1) : '0;
        end
    end

    assign store_we = i_cmd.take_byte && r_have_prev && (r_off < OFF_W'(STORE_DEPTH));
    assign rd_addr  = (ADDR_W'(r_laser) << SLOT_SHIFT) | ADDR_W'(slot_offset(r_step));

    always_comb begin
        o_sts.table_hit  = marker_end && r_have_prev && (r_off == OFF_W'(HIT_OFFSET));
        o_sts.step_last  = (r_step == STEP_W'(REC_BYTES - 1));
        o_sts.laser_last = (r_laser == LASER_W'(LASER_COUNT - 1));
        o_sts.out_free   = !r_out_valid || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog      <= '0;
            r_have_prev <= 1'b0;
            r_off       <= '0;
        end else if (i_cmd.take_byte) begin
            r_prog <= n_prog;
            if (marker_end) begin
                // New reference: the next byte sits just past the marker.
                r_have_prev <= 1'b1;
                r_off       <= OFF_W'(MARKER_LEN);
            end else begin
                r_off <= r_off + 1'b1;
            end
        end
    end

    // Byte store with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            mem[r_off[ADDR_W-1:0]] <= i_status_byte;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_laser  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.read_step;
            if (i_cmd.read_step) begin
                r_step <= o_sts.step_last ? '0 : r_step + 1'b1;
            end
            if (i_cmd.load) begin
                r_laser <= r_laser + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot <= r_step;
        if (r_rd_vld) begin
            r_rec[r_rd_slot] <= r_rdata;
        end
    end

    always_comb begin
        n_out.ring_id           = r_rec[0];
        n_out.vertical_angle    = {r_rec[2],  r_rec[1]};
        n_out.rotation_angle    = {r_rec[4],  r_rec[3]};
        n_out.distance_offset   = {r_rec[6],  r_rec[5]};
        n_out.distance_offset_x = {r_rec[8],  r_rec[7]};
        n_out.distance_offset_y = {r_rec[10], r_rec[9]};
        n_out.vertical_offset   = {r_rec[12], r_rec[11]};
        n_out.horizontal_offset = {r_rec[14], r_rec[13]};
        n_out.focal_range       = {r_rec[16], r_rec[15]};
        n_out.focal_gradient    = {r_rec[18], r_rec[17]};
        n_out.intensity_limits  = {r_rec[20], r_rec[19]};
        n_out.last_record       = o_sts.laser_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_record = r_out;

endmodule

`default_nettype wire

// ===== sv/lidar_calibration_status_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// lidar_calibration_status_deframer_unit: calibration table deframer
// Finds the per-laser calibration table in the sensor status byte stream and
// delivers it as one record per laser.
// ----------------------------------------------------------------------------
// The block takes one status byte per input transaction and searches for
// non-overlapping "UNIT#" markers. Bytes after each marker are kept in a
// 4096-byte store indexed by their distance from the marker start. When a
// marker starts exactly 4160 bytes after the previous one, the block reads
// the 64 per-laser records out of the store and delivers them in order, the
// last with last_record set; any other distance takes the new marker as the
// reference instead. While searching, one byte is accepted per cycle. Once
// the table is found the input stalls: for each record the block issues 21
// reads through the store's single read port, waits for the last read data
// and then loads the output register once the output can take it. After the
// last record the block accepts bytes and drops them until reset. The store
// has no reset; every entry read for a table has been written since the
// reference marker.
`default_nettype none

module lidar_calibration_status_deframer_unit
    import lcsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_status_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_ring_id,
    output logic signed [15:0] o_vertical_angle,
    output logic signed [15:0] o_rotation_angle,
    output logic signed [15:0] o_distance_offset,
    output logic signed [15:0] o_distance_offset_x,
    output logic signed [15:0] o_distance_offset_y,
    output logic signed [15:0] o_vertical_offset,
    output logic signed [15:0] o_horizontal_offset,
    output logic signed [15:0] o_focal_range,
    output logic signed [15:0] o_focal_gradient,
    output logic [15:0]      o_intensity_limits,
    output logic             o_last_record
);

    t_cmd    cmd;
    t_status sts;
    t_record rec;

    // The controller owns sequencing and the input handshake.
    lcsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // The datapath owns the search state, the store and the output register.
    lcsd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_status_byte (i_status_byte),
        .i_ready       (i_ready),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_record      (rec)
    );

    // The signed words are passed through as raw two's complement.
    assign o_ring_id           = rec.ring_id;
    assign o_vertical_angle    = $signed(rec.vertical_angle);
    assign o_rotation_angle    = $signed(rec.rotation_angle);
    assign o_distance_offset   = $signed(rec.distance_offset);
    assign o_distance_offset_x = $signed(rec.distance_offset_x);
    assign o_distance_offset_y = $signed(rec.distance_offset_y);
    assign o_vertical_offset   = $signed(rec.vertical_offset);
    assign o_horizontal_offset = $signed(rec.horizontal_offset);
    assign o_focal_range       = $signed(rec.focal_range);
    assign o_focal_gradient    = $signed(rec.focal_gradient);
    assign o_intensity_limits  = rec.intensity_limits;
    assign o_last_record       = rec.last_record;

endmodule

`default_nettype wire

// ===== tb/sv/lidar_calibration_status_deframer_unit_test.sv =====
// ----------------------------------------------------------------------------
// lidar_calibration_status_deframer_unit_test: calibration deframer testbench
// Feeds status bytes through the valid/ready input, mirrors the marker search
// and the byte store in a local model and checks every calibration record
// field by field against the records that the model predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lidar_calibration_status_deframer_unit_test
    import lcsd_pkg::*;
();

    // Marker characters of "UNIT#".
    localparam logic [7:0] CH_U    = 8'd85;
    localparam logic [7:0] CH_N    = 8'd78;
    localparam logic [7:0] CH_I    = 8'd73;
    localparam logic [7:0] CH_T    = 8'd84;
    localparam logic [7:0] CH_HASH = 8'd35;

    // Opening rows carry a flag: quiet rows are known to yield no record,
    // the other rows take their expectation from the local model.
    localparam logic ROW_QUIET     = 1'b1;
    localparam logic ROW_PREDICTED = 1'b0;
    localparam int   OPENING_ROWS  = 25;

    localparam int NOISE_ITEMS   = 150;
    localparam int LONG_HOLD     = 3000;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1_200_000;
    localparam int PRINT_LIMIT   = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_status_byte = 8'h00;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_ring_id;
    logic signed [15:0] o_vertical_angle;
    logic signed [15:0] o_rotation_angle;
    logic signed [15:0] o_distance_offset;
    logic signed [15:0] o_distance_offset_x;
    logic signed [15:0] o_distance_offset_y;
    logic signed [15:0] o_vertical_offset;
    logic signed [15:0] o_horizontal_offset;
    logic signed [15:0] o_focal_range;
    logic signed [15:0] o_focal_gradient;
    logic [15:0] o_intensity_limits;
    logic        o_last_record;

    lidar_calibration_status_deframer_unit uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_status_byte       (i_status_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_ring_id           (o_ring_id),
        .o_vertical_angle    (o_vertical_angle),
        .o_rotation_angle    (o_rotation_angle),
        .o_distance_offset   (o_distance_offset),
        .o_distance_offset_x (o_distance_offset_x),
        .o_distance_offset_y (o_distance_offset_y),
        .o_vertical_offset   (o_vertical_offset),
        .o_horizontal_offset (o_horizontal_offset),
        .o_focal_range       (o_focal_range),
        .o_focal_gradient    (o_focal_gradient),
        .o_intensity_limits  (o_intensity_limits),
        .o_last_record       (o_last_record)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Local model of the deframer. It keeps its own copy of the byte store,
    // the byte count, the marker match progress and the reference marker.
    // ------------------------------------------------------------------
    logic [7:0]  shadow_store [0:STORE_DEPTH-1];
    logic [31:0] bytes_seen = 32'd0;
    logic [2:0]  match_count = 3'd0;
    logic [31:0] ref_marker_start = 32'd0;
    logic        ref_marker_valid = 1'b0;
    logic        table_found = 1'b0;

    // Records predicted by the model and not yet delivered by the block.
    t_record     pending_records [$];

    int          mismatches = 0;
    int          cycle_count = 0;
    int          produced;

    // Transaction flag that travels with the byte: the row is a quiet one.
    logic        drv_quiet = 1'b0;

    // Stimulus side copy of the marker progress, so that filler bytes can
    // be kept from closing a marker by accident.
    int          gen_progress = 0;

    bit          sender_gaps = 1'b1;
    bit          receiver_gaps = 1'b1;
    bit          long_hold_done = 1'b0;

    logic [8:0]  opening [0:OPENING_ROWS-1];

    function automatic logic [7:0] marker_char(input int idx);
        logic [7:0] c;
        case (idx)
            0:       c = CH_U;
            1:       c = CH_N;
            2:       c = CH_I;
            3:       c = CH_T;
            4:       c = CH_HASH;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Store entries past the end of the store read as zero.
    function automatic logic [7:0] stored(input int offset);
        logic [7:0] v;
        v = (offset < STORE_DEPTH) ? shadow_store[offset] : 8'h00;
        return v;
    endfunction

    // Decodes the whole calibration table out of the model's store.
    task automatic decode_table();
        t_record rec;
        int      b;
        for (int laser = 0; laser < LASER_COUNT; laser++) begin
            b = laser * SLOT_BYTES;
            rec.ring_id           = stored(b + 16);
            rec.vertical_angle    = {stored(b + 18), stored(b + 17)};
            rec.rotation_angle    = {stored(b + 20), stored(b + 19)};
            rec.distance_offset   = {stored(b + 22), stored(b + 21)};
            rec.distance_offset_x = {stored(b + 33), stored(b + 32)};
            rec.distance_offset_y = {stored(b + 35), stored(b + 34)};
            rec.vertical_offset   = {stored(b + 37), stored(b + 36)};
            // The horizontal offset is split: high byte at 48, low byte at 38.
            rec.horizontal_offset = {stored(b + 48), stored(b + 38)};
            rec.focal_range       = {stored(b + 50), stored(b + 49)};
            rec.focal_gradient    = {stored(b + 52), stored(b + 51)};
            rec.intensity_limits  = {stored(b + 54), stored(b + 53)};
            rec.last_record       = (laser == LASER_COUNT - 1);
            pending_records.push_back(rec);
        end
    endtask

    // Advances the model by one accepted status byte and queues any records
    // that the byte releases. The number of queued records is returned.
    task automatic deframe_byte(input logic [7:0] v, output int count);
        logic [31:0] here;
        logic [31:0] offset;
        logic [31:0] start;
        count = 0;
        if (!table_found) begin
            here       = bytes_seen;
            bytes_seen = here + 32'd1;
            // Bytes are kept only after a reference marker and within reach
            // of the store.
            if (ref_marker_valid) begin
                offset = here - ref_marker_start;
                if (offset < STORE_DEPTH) begin
                    shadow_store[offset] = v;
                end
            end
            // A mismatching 'U' restarts the match at its first character.
            if (match_count < MARKER_LEN && v == marker_char(match_count)) begin
                match_count = match_count + 3'd1;
            end else begin
                match_count = (v == CH_U) ? 3'd1 : 3'd0;
            end
            if (match_count == MARKER_LEN) begin
                start       = here - (MARKER_LEN - 1);
                match_count = 3'd0;
                if (ref_marker_valid && (start - ref_marker_start) == MARKER_DISTANCE) begin
                    table_found = 1'b1;
                    decode_table();
                    count = LASER_COUNT;
                end else begin
                    // Wrong distance: the new marker becomes the reference.
                    ref_marker_start = start;
                    ref_marker_valid = 1'b1;
                    for (int k = 0; k < MARKER_LEN; k++) begin
                        shadow_store[k] = marker_char(k);
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Reporting and checking.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    task automatic check_record(input t_record got);
        t_record want;
        want = pending_records.pop_front();
        check_field("ring_id",           16'(got.ring_id),      16'(want.ring_id));
        check_field("vertical_angle",    got.vertical_angle,    want.vertical_angle);
        check_field("rotation_angle",    got.rotation_angle,    want.rotation_angle);
        check_field("distance_offset",   got.distance_offset,   want.distance_offset);
        check_field("distance_offset_x", got.distance_offset_x, want.distance_offset_x);
        check_field("distance_offset_y", got.distance_offset_y, want.distance_offset_y);
        check_field("vertical_offset",   got.vertical_offset,   want.vertical_offset);
        check_field("horizontal_offset", got.horizontal_offset, want.horizontal_offset);
        check_field("focal_range",       got.focal_range,       want.focal_range);
        check_field("focal_gradient",    got.focal_gradient,    want.focal_gradient);
        check_field("intensity_limits",  got.intensity_limits,  want.intensity_limits);
        check_field("last_record",       16'(got.last_record),  16'(want.last_record));
    endtask

    // Both channels are sampled at the rising edge, before any of the
    // nonblocking updates of that edge take effect, so the values seen here
    // are exactly the ones that the block sees for the handshake.
    always @(posedge i_clk) begin : monitor
        t_record got;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                deframe_byte(i_status_byte, produced);
                // A quiet row stands for a typed-in expectation of no record.
                if (drv_quiet && produced != 0) begin
                    report_mismatch("opening row expected no record");
                    pending_records.delete();
                end
            end
            if (o_valid && i_ready) begin
                got.ring_id           = o_ring_id;
                got.vertical_angle    = o_vertical_angle;
                got.rotation_angle    = o_rotation_angle;
                got.distance_offset   = o_distance_offset;
                got.distance_offset_x = o_distance_offset_x;
                got.distance_offset_y = o_distance_offset_y;
                got.vertical_offset   = o_vertical_offset;
                got.horizontal_offset = o_horizontal_offset;
                got.focal_range       = o_focal_range;
                got.focal_gradient    = o_focal_gradient;
                got.intensity_limits  = o_intensity_limits;
                got.last_record       = o_last_record;
                if (pending_records.size() == 0) begin
                    report_mismatch($sformatf("unexpected record, ring_id %h", o_ring_id));
                end else begin
                    check_record(got);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver. It idles in random bursts, and the first time records are
    // due it holds off for a long stretch, so that the output register
    // fills and the block backs up while the sender keeps offering bytes.
    // ------------------------------------------------------------------
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && pending_records.size() != 0) begin
                long_hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender.
    // ------------------------------------------------------------------

    // Offers one byte and returns at the edge where the transaction
    // completes. The stimulus side tracks the marker progress as it goes.
    task automatic push_byte(input logic [7:0] v, input logic quiet);
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_status_byte <= v;
        drv_quiet     <= quiet;
        if (gen_progress < MARKER_LEN && v == marker_char(gen_progress)) begin
            gen_progress++;
        end else begin
            gen_progress = (v == CH_U) ? 1 : 0;
        end
        if (gen_progress == MARKER_LEN) begin
            gen_progress = 0;
        end
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    task automatic send_marker();
        for (int k = 0; k < MARKER_LEN; k++) begin
            push_byte(marker_char(k), ROW_PREDICTED);
        end
    endtask

    // Filler between markers: random content biased toward the extremes
    // and toward marker fragments, but never a complete marker.
    task automatic send_fill(input int count);
        logic [7:0] v;
        repeat (count) begin
            case ($urandom_range(0, 15))
                0, 1:    v = 8'h00;
                2, 3:    v = 8'hFF;
                4:       v = 8'h80;
                5:       v = 8'h7F;
                6:       v = marker_char(gen_progress);
                default: v = 8'($urandom);
            endcase
            if (gen_progress == MARKER_LEN - 1 && v == CH_HASH) begin
                v = CH_HASH + 8'd1;
            end
            push_byte(v, ROW_PREDICTED);
        end
    endtask

    // Stops offering bytes and waits, between edges, until every predicted
    // record has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_records.size() != 0);
    endtask

    initial begin : stimulus
        int sent;
        int frag;
        for (int k = 0; k < STORE_DEPTH; k++) begin
            shadow_store[k] = 8'h00;
        end

        // Opening rows: extremes before any marker, a partial marker whose
        // 'U' restarts the match, a doubled 'U' ahead of a marker at the
        // wrong distance, and two markers back to back.
        opening = '{
            {ROW_QUIET, 8'h00},    {ROW_QUIET, 8'hFF},
            {ROW_QUIET, CH_U},     {ROW_QUIET, CH_N},     {ROW_QUIET, CH_I},
            {ROW_QUIET, CH_U},     {ROW_QUIET, CH_N},     {ROW_QUIET, CH_I},
            {ROW_QUIET, CH_T},     {ROW_PREDICTED, CH_HASH},
            {ROW_QUIET, 8'h00},    {ROW_QUIET, 8'hFF},
            {ROW_QUIET, CH_U},     {ROW_QUIET, CH_U},     {ROW_QUIET, CH_N},
            {ROW_QUIET, CH_I},     {ROW_QUIET, CH_T},     {ROW_PREDICTED, CH_HASH},
            {ROW_QUIET, CH_U},     {ROW_QUIET, CH_N},     {ROW_QUIET, CH_I},
            {ROW_QUIET, CH_T},     {ROW_PREDICTED, CH_HASH},
            {ROW_QUIET, CH_N},     {ROW_QUIET, 8'h7F}
        };

        // Synchronous reset, held low and then released.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < OPENING_ROWS; r++) begin
            push_byte(opening[r][7:0], opening[r][8]);
        end

        // Noise: random bytes, stray 'U's and marker fragments, some of
        // them complete markers that re-arm at short distances.
        sent = 0;
        while (sent < NOISE_ITEMS) begin
            case ($urandom_range(0, 9))
                6, 7: begin
                    push_byte(CH_U, ROW_PREDICTED);
                    sent++;
                end
                8, 9: begin
                    frag = $urandom_range(1, MARKER_LEN);
                    for (int k = 0; k < frag; k++) begin
                        push_byte(marker_char(k), ROW_PREDICTED);
                    end
                    sent += frag;
                end
                default: begin
                    push_byte(8'($urandom), ROW_PREDICTED);
                    sent++;
                end
            endcase
        end

        // Sender pause with nothing in flight.
        wait_drained();
        @(posedge i_clk);

        // Marker chain: one short of the table distance, one beyond it,
        // one further beyond it, and finally the exact distance that
        // releases the table.
        send_marker();
        send_fill(MARKER_DISTANCE - 1 - MARKER_LEN);
        send_marker();
        send_fill(MARKER_DISTANCE + 1 - MARKER_LEN);
        send_marker();
        send_fill(MARKER_DISTANCE + 40 - MARKER_LEN);
        send_marker();
        send_fill(MARKER_DISTANCE - MARKER_LEN);
        send_marker();

        // Bytes after the table, offered while the block is still busy;
        // the block must drop them, a further marker among them.
        send_fill(6);
        send_marker();

        // Pause until the whole table is out, then finish without idling.
        wait_drained();
        @(posedge i_clk);
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        send_fill(8);
        send_marker();
        i_valid <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_records.size() != 0) begin
            report_mismatch($sformatf("%0d records never delivered", pending_records.size()));
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
